### sv/fpm_pkg.sv
`timescale 1ns / 1ps
// Package for the fern posterior engine: sizes, table row type and sequencer states.
// It depends on nothing. Every other file in the project uses it.
package fpm_pkg;

  localparam int MaxFerns   = 8;
  localparam int Features   = 13;
  localparam int CountBits  = 16;
  localparam int PostBits   = 17;
  localparam int SumBits    = 20;
  localparam int ThrBits    = 17;
  localparam int FcBits     = 4;
  localparam int FernBits   = $clog2(MaxFerns);
  localparam int AddrBits   = FernBits + Features;
  localparam int Depth      = MaxFerns * (2 ** Features);
  localparam int NumBits    = CountBits + 17;
  localparam int DenBits    = CountBits + 1;
  localparam int RemBits    = DenBits + 1;
  localparam int IdxBits    = 1;

  localparam logic [IdxBits-1:0] RegFernCount     = 1'd0;
  localparam logic [IdxBits-1:0] RegFernThreshold = 1'd1;

  typedef struct packed {
    logic [CountBits-1:0] pos;
    logic [CountBits-1:0] neg;
    logic [PostBits-1:0]  post;
  } row_t;

  typedef struct packed {
    logic               start;
    logic [NumBits-1:0] num;
    logic [DenBits-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [PostBits-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ACC,
    S_DECIDE,
    S_T_RD,
    S_T_WAIT,
    S_T_DIV,
    S_T_WR,
    S_DONE
  } state_t;

endpackage

### sv/fpm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for fern codes and for measurement results.
// They depend on fpm_pkg for the field widths.
interface fpm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic                          label;
  logic [fpm_pkg::Features-1:0]  code;
  logic                          last;
  modport source (output valid, cmd, label, code, last, input ready);
  modport sink (input valid, cmd, label, code, last, output ready);
endinterface

interface fpm_out_if;
  logic                          valid;
  logic                          ready;
  logic [fpm_pkg::SumBits-1:0]   measure;
  logic                          updated;
  modport source (output valid, measure, updated, input ready);
  modport sink (input valid, measure, updated, output ready);
endinterface

### sv/fpm_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the posterior ratio.
// It depends on fpm_pkg for widths and the request and response types.
module fpm_div (
  input  logic              clk,
  input  logic              rst,
  input  fpm_pkg::div_req_t req,
  output fpm_pkg::div_rsp_t rsp
);

  localparam int CntBits = $clog2(fpm_pkg::NumBits + 1);

  logic                            busy;
  logic [CntBits-1:0]              cnt;
  logic [fpm_pkg::NumBits-1:0]     num;
  logic [fpm_pkg::DenBits-1:0]     den;
  logic [fpm_pkg::RemBits-1:0]     rem;
  logic [fpm_pkg::PostBits-1:0]    quot;
  logic                            done;
  logic [fpm_pkg::RemBits-1:0]     trial;
  logic                            fits;

  assign trial = {rem[fpm_pkg::RemBits-2:0], num[fpm_pkg::NumBits-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CntBits'(fpm_pkg::NumBits);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The ratio never exceeds one in Q1.16, so only the low quotient bits are kept.
  always_ff @(posedge clk) begin
    if (req.start) begin
      num  <= req.num;
      den  <= req.den;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      num  <= {num[fpm_pkg::NumBits-2:0], 1'b0};
      rem  <= fits ? (trial - {1'b0, den}) : trial;
      quot <= {quot[fpm_pkg::PostBits-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

### sv/fern_posterior_train_measure_core.sv
`timescale 1ns / 1ps
// Fern posterior engine top level: table memory, sequencer, divider and channels.
// Ready is high only in S_IDLE; a code that is summed then passes through S_ACC, where
// ready is low. Training visits each summed fern in turn (read, wait, divide, write);
// the divide is skipped if pos is zero. out_ch.valid is registered in S_DONE, reached
// from S_DECIDE or from the last table write; reset is synchronous and a clearing pass
// zeroes all 65536 table rows first. Depends on fpm_pkg, fpm_if and fpm_div.
module fern_posterior_train_measure_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fpm_pkg::IdxBits-1:0]       cfg_index,
  input  logic [fpm_pkg::ThrBits-1:0]       cfg_data,
  fpm_in_if.sink                            in_ch,
  fpm_out_if.source                         out_ch
);

  fpm_pkg::state_t state, state_next;

  logic [fpm_pkg::FcBits-1:0]   fern_count;
  logic [fpm_pkg::ThrBits-1:0]  fern_threshold;
  logic [fpm_pkg::FcBits-1:0]   n_act;
  logic [fpm_pkg::FcBits-1:0]   fern_position;
  logic [fpm_pkg::SumBits-1:0]  running_sum;
  logic [fpm_pkg::Features-1:0] codes [fpm_pkg::MaxFerns];
  logic                         cmd_r, label_r, last_r, train_r;
  logic [fpm_pkg::FcBits-1:0]   tidx;
  logic [fpm_pkg::CountBits-1:0] pos_r, neg_r;
  logic [fpm_pkg::PostBits-1:0] post_r;
  logic [fpm_pkg::AddrBits-1:0] clr_cnt;

  fpm_pkg::row_t                mem [fpm_pkg::Depth];
  fpm_pkg::row_t                rdata, wdata;
  logic [fpm_pkg::AddrBits-1:0] rd_addr, wr_addr, t_addr;
  logic                         mem_we;

  fpm_pkg::div_req_t dreq;
  fpm_pkg::div_rsp_t drsp;

  logic                         accept, take, fern_open, load_out;
  logic                         train_now;
  logic [fpm_pkg::SumBits:0]    sum_wide;
  logic [fpm_pkg::SumBits:0]    thr_n;
  logic [fpm_pkg::SumBits:0]    half_n;
  logic [fpm_pkg::CountBits-1:0] pos_new, neg_new;
  logic [fpm_pkg::DenBits-1:0]  total;
  logic [fpm_pkg::CountBits-1:0] max_cnt;

  assign max_cnt = '1;

  always_comb begin
    if (fern_count == '0) begin
      n_act = fpm_pkg::FcBits'(1);
    end else if (fern_count > fpm_pkg::FcBits'(fpm_pkg::MaxFerns)) begin
      n_act = fpm_pkg::FcBits'(fpm_pkg::MaxFerns);
    end else begin
      n_act = fern_count;
    end
  end

  assign accept    = in_ch.valid && in_ch.ready;
  assign fern_open = fern_position < n_act;
  assign take      = accept && fern_open;
  assign t_addr    = {tidx[fpm_pkg::FernBits-1:0], codes[tidx[fpm_pkg::FernBits-1:0]]};
  assign sum_wide  = {1'b0, running_sum} + (fpm_pkg::SumBits + 1)'(rdata.post);
  assign thr_n     = (fpm_pkg::SumBits + 1)'(fern_threshold) * (fpm_pkg::SumBits + 1)'(n_act);
  assign half_n    = (fpm_pkg::SumBits + 1)'(n_act) << 15;
  assign train_now = cmd_r && (label_r ? ({1'b0, running_sum} <= thr_n)
                                       : ({1'b0, running_sum} >= half_n));
  assign load_out  = (state == fpm_pkg::S_DONE) && (!out_ch.valid || out_ch.ready);

  always_comb begin
    pos_new = rdata.pos;
    neg_new = rdata.neg;
    if (label_r) begin
      if (rdata.pos != max_cnt) pos_new = rdata.pos + 1'b1;
    end else begin
      if (rdata.neg != max_cnt) neg_new = rdata.neg + 1'b1;
    end
  end
  assign total = fpm_pkg::DenBits'(pos_new) + fpm_pkg::DenBits'(neg_new);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fpm_pkg::S_CLEAR: begin
        if (clr_cnt == '1) state_next = fpm_pkg::S_IDLE;
      end
      fpm_pkg::S_IDLE: begin
        if (accept) begin
          if (fern_open) state_next = fpm_pkg::S_ACC;
          else if (in_ch.last) state_next = fpm_pkg::S_DECIDE;
        end
      end
      fpm_pkg::S_ACC: state_next = last_r ? fpm_pkg::S_DECIDE : fpm_pkg::S_IDLE;
      fpm_pkg::S_DECIDE: begin
        state_next = (train_now && fern_position != '0) ? fpm_pkg::S_T_RD : fpm_pkg::S_DONE;
      end
      fpm_pkg::S_T_RD: state_next = fpm_pkg::S_T_WAIT;
      fpm_pkg::S_T_WAIT: state_next = (pos_new == '0) ? fpm_pkg::S_T_WR : fpm_pkg::S_T_DIV;
      fpm_pkg::S_T_DIV: if (drsp.done) state_next = fpm_pkg::S_T_WR;
      fpm_pkg::S_T_WR: begin
        state_next = (tidx + 1'b1 == fern_position) ? fpm_pkg::S_DONE : fpm_pkg::S_T_RD;
      end
      fpm_pkg::S_DONE: if (load_out) state_next = fpm_pkg::S_IDLE;
      default: state_next = fpm_pkg::S_CLEAR;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    rd_addr     = t_addr;
    wr_addr     = t_addr;
    wdata       = '{pos: pos_r, neg: neg_r, post: post_r};
    dreq.start  = 1'b0;
    dreq.num    = fpm_pkg::NumBits'({pos_new, 16'b0}) + fpm_pkg::NumBits'(total >> 1);
    dreq.den    = total;
    unique case (state)
      fpm_pkg::S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_cnt;
        wdata   = '0;
      end
      fpm_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        rd_addr     = {fern_position[fpm_pkg::FernBits-1:0], in_ch.code};
      end
      fpm_pkg::S_T_WAIT: dreq.start = (pos_new != '0);
      fpm_pkg::S_T_WR: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wdata;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= fpm_pkg::S_CLEAR;
      clr_cnt        <= '0;
      fern_count     <= fpm_pkg::FcBits'(8);
      fern_threshold <= fpm_pkg::ThrBits'(39322);
      fern_position  <= '0;
      running_sum    <= '0;
      out_ch.valid   <= 1'b0;
      tidx           <= '0;
    end else begin
      state <= state_next;
      if (state == fpm_pkg::S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (cfg_we) begin
        unique case (cfg_index)
          fpm_pkg::RegFernCount:     fern_count <= cfg_data[fpm_pkg::FcBits-1:0];
          fpm_pkg::RegFernThreshold: fern_threshold <= cfg_data;
          default: ;
        endcase
      end
      if (take) fern_position <= fern_position + 1'b1;
      if (state == fpm_pkg::S_ACC) begin
        running_sum <= sum_wide[fpm_pkg::SumBits] ? '1 : sum_wide[fpm_pkg::SumBits-1:0];
      end
      if (state == fpm_pkg::S_DECIDE) tidx <= '0;
      if (state == fpm_pkg::S_T_WR) tidx <= tidx + 1'b1;
      if (load_out) begin
        out_ch.valid  <= 1'b1;
        fern_position <= '0;
        running_sum   <= '0;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) codes[fern_position[fpm_pkg::FernBits-1:0]] <= in_ch.code;
    if (accept) begin
      cmd_r   <= in_ch.cmd;
      label_r <= in_ch.label;
      last_r  <= in_ch.last;
    end
    if (state == fpm_pkg::S_DECIDE) train_r <= train_now;
    if (state == fpm_pkg::S_T_WAIT) begin
      pos_r  <= pos_new;
      neg_r  <= neg_new;
      post_r <= '0;
    end
    if (state == fpm_pkg::S_T_DIV && drsp.done) post_r <= drsp.quot;
    if (load_out) begin
      out_ch.measure <= running_sum;
      out_ch.updated <= train_r;
    end
  end

  fpm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

endmodule
